>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> src/lrma_pkg.sv
// Types and constants of the latency request minimum aggregator.
package lrma_pkg;

  localparam int SLOTS      = 32;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CLASSES    = 2;
  localparam int CLASS_W    = 1;
  localparam int OWNER_BITS = 16;
  localparam int HANDLE_W   = 6;
  localparam int VALUE_W    = 32;
  localparam int CFG_ADDR_W = 1;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 80;

  localparam logic signed [VALUE_W-1:0] TOP_VALUE   = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] NO_REQUESTS = 32'shFFFF_FFFF;

  localparam logic [SLOT_W-1:0]   SLOT_LAST  = SLOT_W'(SLOTS - 1);
  localparam logic [HANDLE_W-1:0] HANDLE_MAX = HANDLE_W'(SLOTS);

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_CANCEL  = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_EVAL    = 2'd3
  } lrma_cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } lrma_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_ADD,
    ST_DONE
  } lrma_state_t;

  typedef struct packed {
    logic [CLASS_W-1:0]    cls;
    logic [VALUE_W-1:0]    value;
    logic [OWNER_BITS-1:0] owner;
  } lrma_entry_t;

endpackage

>>> src/lrma_slot_store.sv
// Slot table memory: one write port, one registered read port.
module lrma_slot_store (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [lrma_pkg::SLOT_W-1:0]      wr_addr,
  input  lrma_pkg::lrma_entry_t            wr_data,
  input  logic                             rd_en,
  input  logic [lrma_pkg::SLOT_W-1:0]      rd_addr,
  output lrma_pkg::lrma_entry_t            rd_data
);

  lrma_pkg::lrma_entry_t mem [lrma_pkg::SLOTS];
  lrma_pkg::lrma_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/latency_request_min_aggregator_unit.sv
// Top level of the latency request minimum aggregator.
//
// Input channel in_*: one command per transfer (add, cancel by handle,
// release owner, re-evaluate). Output channel out_*: one result per command
// with status, new handle and both class aggregates with change flags.
// Configuration: cfg_we writes cfg_wdata into the floor register picked by
// cfg_addr (0 cpu_dma, 1 network); it takes effect at the next result registered.
//
// Each command scans all 32 slots through the single read port of the slot
// memory, one slot per cycle. After the scan it passes through a wait step and
// an add step, registers the result in its done step and returns to idle,
// where the next command is taken.
// Finished results sit in the output register; the next command is taken
// while a result waits. If out_tready stays low, the following command
// holds in its final step until the register frees up.
// Reset (rst_n low, synchronous) frees every slot, sets both floors and both
// last-reported aggregates to -1 and drops out_tvalid. The slot memory needs
// no clearing pass.
module latency_request_min_aggregator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] request_value, [37:32] handle_in, [53:38] owner_id, rest zero
  input  logic [lrma_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] cmd, [2] qos_class
  input  logic [lrma_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] status, [7:2] handle, [39:8] cpu_latency, [40] cpu_changed,
  // [72:41] net_latency, [73] net_changed, rest zero
  output logic [lrma_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [lrma_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lrma_pkg::VALUE_W-1:0]        cfg_wdata
);

  lrma_pkg::lrma_state_t state_r, state_nxt;

  logic [lrma_pkg::SLOT_W-1:0]     cnt_r;
  logic                            rd_vld_r;
  logic [lrma_pkg::SLOT_W-1:0]     rd_idx_r;
  logic [lrma_pkg::SLOTS-1:0]      used_r, used_nxt;
  logic                            free_found_r;
  logic [lrma_pkg::SLOT_W-1:0]     free_idx_r;
  logic                            out_tvalid_r;
  logic [lrma_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic signed [lrma_pkg::VALUE_W-1:0] best_r  [lrma_pkg::CLASSES];
  logic signed [lrma_pkg::VALUE_W-1:0] best_nxt[lrma_pkg::CLASSES];
  logic signed [lrma_pkg::VALUE_W-1:0] rep_r   [lrma_pkg::CLASSES];
  logic signed [lrma_pkg::VALUE_W-1:0] floor_r [lrma_pkg::CLASSES];
  logic signed [lrma_pkg::VALUE_W-1:0] agg     [lrma_pkg::CLASSES];
  logic        [lrma_pkg::CLASSES-1:0] chg;

  lrma_pkg::lrma_cmd_t             cmd_r;
  logic [lrma_pkg::CLASS_W-1:0]    cls_r;
  logic signed [lrma_pkg::VALUE_W-1:0] val_r;
  logic [lrma_pkg::OWNER_BITS-1:0] owner_r;
  lrma_pkg::lrma_status_t          status_r;
  logic [lrma_pkg::HANDLE_W-1:0]   handle_r;

  logic                            in_fire;
  logic                            out_free;
  logic                            load_out;
  logic                            mem_rd_en;
  logic                            mem_wr_en;
  lrma_pkg::lrma_entry_t           rd_data;
  lrma_pkg::lrma_entry_t           wr_data;

  lrma_pkg::lrma_cmd_t             in_cmd;
  logic [lrma_pkg::HANDLE_W-1:0]   in_handle;
  logic [lrma_pkg::SLOT_W-1:0]     in_hidx;
  logic                            cancel_hit;

  logic                            entry_used;
  logic                            rel_hit;
  logic                            count_hit;
  logic signed [lrma_pkg::VALUE_W-1:0] entry_val;
  logic                            add_ok;

  assign in_cmd     = lrma_pkg::lrma_cmd_t'(in_tuser[1:0]);
  assign in_handle  = in_tdata[37:32];
  assign in_hidx    = lrma_pkg::SLOT_W'(in_handle - 1'b1);
  assign cancel_hit = (in_handle != '0) && (in_handle <= lrma_pkg::HANDLE_MAX) &&
                      used_r[in_hidx];
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;

  assign entry_used = used_r[rd_idx_r];
  assign entry_val  = $signed(rd_data.value);
  assign rel_hit    = rd_vld_r && (cmd_r == lrma_pkg::CMD_RELEASE) && entry_used &&
                      (rd_data.owner == owner_r);
  assign count_hit  = rd_vld_r && entry_used && !rel_hit && (entry_val > 0) &&
                      (entry_val < best_r[rd_data.cls]);
  assign add_ok     = (cmd_r == lrma_pkg::CMD_ADD) && free_found_r;

  assign wr_data.cls   = cls_r;
  assign wr_data.value = val_r;
  assign wr_data.owner = owner_r;

  lrma_slot_store u_slot_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (free_idx_r),
    .wr_data (wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrma_pkg::ST_IDLE: if (in_tvalid) state_nxt = lrma_pkg::ST_SCAN;
      lrma_pkg::ST_SCAN: if (cnt_r == lrma_pkg::SLOT_LAST) state_nxt = lrma_pkg::ST_WAIT;
      lrma_pkg::ST_WAIT: state_nxt = lrma_pkg::ST_ADD;
      lrma_pkg::ST_ADD:  state_nxt = lrma_pkg::ST_DONE;
      lrma_pkg::ST_DONE: if (out_free) state_nxt = lrma_pkg::ST_IDLE;
      default:           state_nxt = lrma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      lrma_pkg::ST_IDLE: in_tready = 1'b1;
      lrma_pkg::ST_SCAN: mem_rd_en = 1'b1;
      lrma_pkg::ST_WAIT: ;
      lrma_pkg::ST_ADD:  mem_wr_en = add_ok;
      lrma_pkg::ST_DONE: load_out  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    used_nxt = used_r;
    if (in_fire && (in_cmd == lrma_pkg::CMD_CANCEL) && cancel_hit) begin
      used_nxt[in_hidx] = 1'b0;
    end
    if (rel_hit) begin
      used_nxt[rd_idx_r] = 1'b0;
    end
    if (mem_wr_en) begin
      used_nxt[free_idx_r] = 1'b1;
    end
  end

  always_comb begin
    for (int c = 0; c < lrma_pkg::CLASSES; c++) begin
      best_nxt[c] = best_r[c];
    end
    if (in_fire) begin
      for (int c = 0; c < lrma_pkg::CLASSES; c++) begin
        best_nxt[c] = lrma_pkg::TOP_VALUE;
      end
    end else if (count_hit) begin
      best_nxt[rd_data.cls] = entry_val;
    end else if ((state_r == lrma_pkg::ST_ADD) && add_ok && (val_r > 0) &&
                 (val_r < best_r[cls_r])) begin
      best_nxt[cls_r] = val_r;
    end
  end

  always_comb begin
    for (int c = 0; c < lrma_pkg::CLASSES; c++) begin
      agg[c] = (best_r[c] < floor_r[c]) ? floor_r[c] : best_r[c];
      if (agg[c] == lrma_pkg::TOP_VALUE) begin
        agg[c] = lrma_pkg::NO_REQUESTS;
      end
      chg[c] = (agg[c] != rep_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lrma_pkg::ST_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      used_r       <= '0;
      free_found_r <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int c = 0; c < lrma_pkg::CLASSES; c++) begin
        rep_r[c]   <= lrma_pkg::NO_REQUESTS;
        floor_r[c] <= lrma_pkg::NO_REQUESTS;
      end
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      rd_vld_r <= mem_rd_en;
      if (in_fire) begin
        cnt_r <= '0;
      end else if (mem_rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (in_fire) begin
        free_found_r <= 1'b0;
      end else if (rd_vld_r && !entry_used && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (cfg_we) begin
        floor_r[cfg_addr] <= $signed(cfg_wdata);
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
        for (int c = 0; c < lrma_pkg::CLASSES; c++) begin
          rep_r[c] <= agg[c];
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    for (int c = 0; c < lrma_pkg::CLASSES; c++) begin
      best_r[c] <= best_nxt[c];
    end
    if (rd_vld_r && !entry_used && !free_found_r) begin
      free_idx_r <= rd_idx_r;
    end
    if (in_fire) begin
      cmd_r    <= in_cmd;
      cls_r    <= in_tuser[2];
      val_r    <= $signed(in_tdata[31:0]);
      owner_r  <= in_tdata[53:38];
      handle_r <= '0;
      if ((in_cmd == lrma_pkg::CMD_CANCEL) && !cancel_hit) begin
        status_r <= lrma_pkg::STS_NOT_FOUND;
      end else begin
        status_r <= lrma_pkg::STS_OK;
      end
    end else if ((state_r == lrma_pkg::ST_ADD) && (cmd_r == lrma_pkg::CMD_ADD)) begin
      if (free_found_r) begin
        handle_r <= lrma_pkg::HANDLE_W'(free_idx_r) + 1'b1;
      end else begin
        status_r <= lrma_pkg::STS_FULL;
      end
    end
    if (load_out) begin
      out_tdata_r <= {6'd0, chg[1], agg[1], chg[0], agg[0], handle_r, status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> src/lrma_checker.sv
// Port-level checker for the aggregator, bound to the top level.
`include "assert_macros.svh"

module lrma_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lrma_pkg::OUT_TDATA_W-1:0] out_tdata
);

  lrma_pkg::lrma_status_t          out_sts;
  logic [lrma_pkg::HANDLE_W-1:0]   out_hnd;

  assign out_sts = lrma_pkg::lrma_status_t'(out_tdata[1:0]);
  assign out_hnd = out_tdata[7:2];

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_one_cmd_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMPLY(a_status_code, clk, rst_n, out_tvalid, out_sts <= lrma_pkg::STS_FULL)
  `ASSERT_IMPLY(a_handle_ok, clk, rst_n, out_tvalid && out_hnd != '0, out_sts == lrma_pkg::STS_OK)

endmodule

bind latency_request_min_aggregator_unit lrma_checker u_lrma_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
